// File: design/integer_to_ascii_formatter_core_defines.svh
// Assertion macros shared by the formatter core modules.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/itoa_pkg.sv
// Types, codes and character helpers for the integer-to-ASCII formatter.
// Used by itoa_dabble and integer_to_ascii_formatter_core; no dependencies.
package itoa_pkg;

	localparam int MAG_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int HEX_DIGITS = 16;

	localparam logic [2:0] KIND_SDEC = 3'd0;
	localparam logic [2:0] KIND_UDEC = 3'd1;
	localparam logic [2:0] KIND_HEXL = 3'd2;
	localparam logic [2:0] KIND_HEXU = 3'd3;
	localparam logic [2:0] KIND_PTR  = 3'd4;

	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CASE_GAP  = 8'd32;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic [4:0] char_count;
		logic       last_char;
	} res_t;

	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} dd_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_PREFIX,
		ST_EMIT
	} state_t;

	function automatic logic [7:0] digit_char(logic [3:0] nib, logic upper);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'b0000, nib};
		end else begin
			c = CH_LOWER_A + {4'b0000, nib} - 8'd10;
			if (upper) begin
				c = c - CASE_GAP;
			end
		end
		return c;
	endfunction

endpackage

// File: design/integer_to_ascii_formatter_core.sv
// Integer-to-ASCII formatter: one request in, its characters out MSD first, one per strobe.
// Depends on itoa_pkg, itoa_dabble and integer_to_ascii_formatter_core_defines.svh.
//
// A request is taken when start is high and busy is low; busy then stays high until the
// last character has been produced. Each character appears on result for exactly one cycle
// with result_valid high, and the receiver must take it then, as there is no back-pressure.
// Characters of one request come in consecutive cycles with last_char on the final one.
// Decimal kinds first pass through the bit-serial BCD converter, which shifts in every
// magnitude bit and then hands over its ten digits. Leading zero digits are then suppressed
// (up to 9 for decimal, 7 for hex, 15 for pointer) before the characters follow. Hex and
// pointer kinds skip the converter. Each character is registered in the result register
// in the cycle after it is formed, so the last one is shown with busy already low.
// A request with an unused kind code (5 to 7) is taken, produces nothing and leaves busy low.
`include "integer_to_ascii_formatter_core_defines.svh"
module integer_to_ascii_formatter_core import itoa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic result_valid,
	output res_t result
);

	state_t state_q, state_d;

	logic [4*HEX_DIGITS-1:0] dig_q;
	logic [4:0]              ndig_q;
	logic [1:0]              pfx_q;
	logic                    ptr_q;
	logic                    upper_q;
	logic [4:0]              cnt_q;
	res_t                    res_q, res_d;
	logic                    res_vld_q, res_vld_d;

	logic                    accept;
	logic [MAG_W-1:0]        low32;
	logic                    neg;
	logic                    dd_load;
	dd_stat_t                dd_stat;
	logic [3:0]              idx;
	logic [3:0]              cur_nib;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign low32  = req.value[MAG_W-1:0];
	assign neg    = (req.req_type == KIND_SDEC) && low32[MAG_W-1];
	assign dd_load = accept && (req.req_type == KIND_SDEC || req.req_type == KIND_UDEC);

	itoa_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (dd_load),
		.bin    (neg ? (~low32 + 32'd1) : low32),
		.stat   (dd_stat)
	);

	assign idx     = 4'(ndig_q - 5'd1);
	assign cur_nib = dig_q[{idx, 2'b00} +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_vld_q <= res_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			cnt_q   <= '0;
			ptr_q   <= (req.req_type == KIND_PTR);
			upper_q <= (req.req_type == KIND_HEXU);
			pfx_q   <= (req.req_type == KIND_PTR) ? 2'd2 : {1'b0, neg};
			if (req.req_type == KIND_PTR) begin
				dig_q  <= req.value;
				ndig_q <= 5'd16;
			end else begin
				dig_q  <= {32'd0, low32};
				ndig_q <= 5'd8;
			end
		end else begin
			unique case (state_q)
				ST_CONV: begin
					if (dd_stat.done) begin
						dig_q  <= {{(4*HEX_DIGITS-BCD_W){1'b0}}, dd_stat.bcd};
						ndig_q <= 5'(BCD_DIGITS);
					end
				end
				ST_SKIP: begin
					if (cur_nib == 4'd0 && ndig_q != 5'd1) begin
						ndig_q <= ndig_q - 5'd1;
					end
				end
				ST_PREFIX: begin
					pfx_q <= pfx_q - 2'd1;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_EMIT: begin
					ndig_q <= ndig_q - 5'd1;
					cnt_q  <= cnt_q + 5'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d          = state_q;
		res_vld_d        = 1'b0;
		res_d.ascii_char = digit_char(cur_nib, upper_q);
		res_d.char_count = cnt_q + 5'd1;
		res_d.last_char  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					priority if (req.req_type == KIND_SDEC || req.req_type == KIND_UDEC) begin
						state_d = ST_CONV;
					end else if (req.req_type == KIND_HEXL || req.req_type == KIND_HEXU
						|| req.req_type == KIND_PTR) begin
						state_d = ST_SKIP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CONV: begin
				if (dd_stat.done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// advance once the top digit is nonzero or only the units digit is left
				if (cur_nib != 4'd0 || ndig_q == 5'd1) begin
					state_d = (pfx_q != 2'd0) ? ST_PREFIX : ST_EMIT;
				end
			end
			ST_PREFIX: begin
				res_vld_d = 1'b1;
				if (ptr_q) begin
					res_d.ascii_char = (pfx_q == 2'd2) ? CH_ZERO : CH_X;
				end else begin
					res_d.ascii_char = CH_MINUS;
				end
				if (pfx_q == 2'd1) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				res_vld_d = 1'b1;
				if (ndig_q == 5'd1) begin
					res_d.last_char = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	`ITOA_ASSERT_NOW(a_count_nonzero, result_valid, result.char_count != 5'd0, "char count is zero")
	`ITOA_ASSERT_NEXT(a_gap_after_last, result_valid && result.last_char, !result_valid,
		"character follows the last one")
	`ITOA_ASSERT_NEXT(a_no_gap_inside, result_valid && !result.last_char, result_valid,
		"gap inside a character run")
	`ITOA_ASSERT_NOW(a_emit_has_digit, state_q == ST_EMIT, ndig_q != 5'd0,
		"emitting with no digits left")
	`ITOA_ASSERT_NEXT(a_busy_after_take, start && !busy && req.req_type <= KIND_PTR, busy,
		"valid request did not raise busy")

endmodule

// File: design/itoa_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on itoa_pkg and integer_to_ascii_formatter_core_defines.svh.
`include "integer_to_ascii_formatter_core_defines.svh"
module itoa_dabble import itoa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [MAG_W-1:0] bin,
	output dd_stat_t         stat
);

	logic [MAG_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [4:0]       cnt_q;
	logic             run_q;
	logic             done_q;

	// correct every digit that would overflow on the next doubling
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(MAG_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (run_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[MAG_W-1]};
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
		end
	end

	assign stat.done = done_q;
	assign stat.bcd  = bcd_q;

	`ITOA_ASSERT_NEXT(a_dd_done_pulse, done_q, !done_q, "converter done held longer than a cycle")
	`ITOA_ASSERT_NOW(a_dd_done_idle, done_q, !run_q, "converter done while still shifting")
	`ITOA_ASSERT_NEXT(a_dd_load_runs, load, run_q, "converter did not start after load")

endmodule

// File: sim/tb_integer_to_ascii_formatter_core.sv
// Testbench for integer_to_ascii_formatter_core: directed rows, then random requests with idle gaps.
// Each character is checked against a text predictor or a typed-in string; needs itoa_pkg and the core.
`timescale 1ns / 100ps
module tb_integer_to_ascii_formatter_core;
	import itoa_pkg::*;

	localparam logic [2:0] KIND_RSVD5 = 3'd5;
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;
	localparam int ROWS           = 22;
	localparam int RANDOM_ITEMS   = 290;
	localparam int MAX_GAP        = 18;
	localparam int DRAIN_CYCLES   = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic result_valid;
	res_t result;

	// text typed in for the request now on req; empty means use the predictor
	string expected_text;
	res_t  pending_chars[$];
	int    error_count;
	int    quiet_cycles;
	int    sent_total;

	req_t row_req [ROWS] = '{
		{KIND_SDEC, 64'h0000_0000_0000_0000},
		{KIND_SDEC, 64'h0000_0000_8000_0000},
		{KIND_SDEC, 64'h0000_0000_7fff_ffff},
		{KIND_SDEC, 64'h0000_0000_ffff_ffff},
		{KIND_SDEC, 64'hffff_ffff_0000_0005},
		{KIND_SDEC, 64'h0000_0000_ffff_ff85},
		{KIND_UDEC, 64'h0000_0000_0000_0000},
		{KIND_UDEC, 64'h0000_0000_ffff_ffff},
		{KIND_UDEC, 64'habcd_0000_0000_0009},
		{KIND_UDEC, 64'h0000_0000_3b9a_ca00},
		{KIND_HEXL, 64'h0000_0000_0000_0000},
		{KIND_HEXL, 64'hffff_ffff_dead_beef},
		{KIND_HEXU, 64'h0000_0000_dead_beef},
		{KIND_HEXU, 64'h1234_5678_0000_abcd},
		{KIND_HEXL, 64'h0000_0000_0abc_0123},
		{KIND_PTR,  64'h0000_0000_0000_0000},
		{KIND_PTR,  64'hffff_ffff_ffff_ffff},
		{KIND_PTR,  64'h8000_0000_0000_0000},
		{KIND_PTR,  64'h0000_0000_1234_abcd},
		{KIND_RSVD5, 64'hffff_ffff_ffff_ffff},
		{KIND_RSVD6, 64'h0000_0000_0000_0000},
		{KIND_RSVD7, 64'h0000_0000_8000_0000}
	};

	string row_text [ROWS] = '{
		"0", "-2147483648", "2147483647", "-1", "5", "",
		"0", "4294967295", "9", "1000000000",
		"0", "deadbeef", "DEADBEEF", "ABCD", "",
		"0x0", "0xffffffffffffffff", "0x8000000000000000", "",
		"", "", ""
	};

	integer_to_ascii_formatter_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result)
	);

	always #2 clk = ~clk;

	// Text the block should print for one request; empty for unused kinds.
	function automatic string format_text(input req_t r);
		logic [31:0] low;
		logic [63:0] mag;
		string       s;
		low = r.value[31:0];
		s = "";
		case (r.req_type)
			KIND_SDEC: begin
				if (low[31]) begin
					mag = 64'h1_0000_0000 - {32'h0, low};
					s = {"-", $sformatf("%0d", mag)};
				end else begin
					s = $sformatf("%0d", low);
				end
			end
			KIND_UDEC: s = $sformatf("%0d", low);
			KIND_HEXL: s = $sformatf("%0h", low);
			KIND_HEXU: begin
				s = $sformatf("%0h", low);
				for (int i = 0; i < s.len(); i++) begin
					if (s[i] >= "a" && s[i] <= "f") begin
						s[i] = s[i] - CASE_GAP;
					end
				end
			end
			KIND_PTR: s = {"0x", $sformatf("%0h", r.value)};
			default: s = "";
		endcase
		return s;
	endfunction

	function automatic void queue_text(input string s);
		res_t c;
		for (int i = 0; i < s.len(); i++) begin
			c.ascii_char = s[i];
			c.char_count = 5'(i + 1);
			c.last_char  = (i == s.len() - 1);
			pending_chars.push_back(c);
		end
	endfunction

	// Check each character first, then queue the text of a request taken at this edge.
	always @(posedge clk) begin
		res_t want;
		if (result_valid) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none actual %h", $time, result);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				if (result.ascii_char !== want.ascii_char) begin
					$display("%0t: ascii_char mismatch: expected %h actual %h",
						$time, want.ascii_char, result.ascii_char);
					error_count++;
				end
				if (result.char_count !== want.char_count) begin
					$display("%0t: char_count mismatch: expected %0d actual %0d",
						$time, want.char_count, result.char_count);
					error_count++;
				end
				if (result.last_char !== want.last_char) begin
					$display("%0t: last_char mismatch: expected %b actual %b",
						$time, want.last_char, result.last_char);
					error_count++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			queue_text(expected_text != "" ? expected_text : format_text(req));
		end
	end

	// Count cycles in which neither side moves anything.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Idle for a random number of cycles, except in every third stretch of 40 requests.
	task automatic send_request(input req_t r, input string text);
		int gap;
		gap = (((sent_total / 40) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		req           <= r;
		expected_text <= text;
		do @(posedge clk); while (busy);
		sent_total++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	function automatic req_t random_request();
		req_t        r;
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(0, 15) == 0) begin
			r.req_type = 3'($urandom_range(KIND_RSVD5, KIND_RSVD7));
		end else begin
			r.req_type = 3'($urandom_range(KIND_SDEC, KIND_PTR));
		end
		// vary the digit count: full width, shifted down, tiny, or near the sign boundary
		case ($urandom_range(0, 3))
			0: r.value = v;
			1: r.value = v >> $urandom_range(0, 63);
			2: r.value = {v[63:32] & {32{v[0]}}, 32'($urandom_range(0, 20))};
			default: r.value = {v[63:32], 32'h8000_0000 ^ 32'($urandom_range(0, 3))};
		endcase
		return r;
	endfunction

	initial begin
		int   valid_sent;
		req_t r;
		arst_n        = 1'b0;
		start         = 1'b0;
		req           = '0;
		expected_text = "";
		error_count   = 0;
		sent_total    = 0;
		valid_sent    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < ROWS; i++) begin
			send_request(row_req[i], row_text[i]);
		end

		while (valid_sent < RANDOM_ITEMS) begin
			if (valid_sent == 110 || valid_sent == 220) begin
				wait_drained();
			end
			r = random_request();
			send_request(r, "");
			if (r.req_type <= KIND_PTR) begin
				valid_sent++;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			$display("%0t: %0d characters never arrived", $time, pending_chars.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/itoa_pkg.sv
design/itoa_dabble.sv
design/integer_to_ascii_formatter_core.sv
sim/tb_integer_to_ascii_formatter_core.sv
